>>> hw/rtl/ggnh_pkg.sv
// ggnh_pkg: types, widths and codes shared by the greedy next hop unit
// no dependencies; imported by ggnh_dist_unit and greedy_geographic_next_hop_unit
`timescale 1ns / 1ps

package ggnh_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int COORD_W     = 16;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int ENTRY_W     = ID_W + 2 * COORD_W;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic MODE_HELLO = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_Y = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [ID_W-1:0]           neighbor_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] next_hop;
    logic            hop_found;
    logic            table_full_drop;
  } rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } entry_t;

  typedef struct packed {
    logic            own;
    logic [ID_W-1:0] id;
  } dist_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_RESP
  } state_e;

endpackage

>>> hw/rtl/ggnh_ram.sv
// ggnh_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ggnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ggnh_dist_unit.sv
// ggnh_dist_unit: three stage squared euclidean distance pipeline with a tag
// depends on ggnh_pkg
`timescale 1ns / 1ps

module ggnh_dist_unit
  import ggnh_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  dist_tag_t                 tag_i,
  input  logic signed [COORD_W-1:0] ax_i,
  input  logic signed [COORD_W-1:0] ay_i,
  input  logic signed [COORD_W-1:0] bx_i,
  input  logic signed [COORD_W-1:0] by_i,
  output logic                      valid_o,
  output dist_tag_t                 tag_o,
  output logic [DIST_W-1:0]         dist_o,
  output logic                      busy_o
);

  logic                     v1_q, v2_q, v3_q;
  dist_tag_t                t1_q, t2_q, t3_q;
  logic signed [DIFF_W-1:0] dx1_q, dy1_q, dx1_d, dy1_d;
  logic [SQ_W-1:0]          sx2_q, sy2_q, sx2_d, sy2_d;
  logic [DIST_W-1:0]        d3_q, d3_d;
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;

  always_comb begin
    dx1_d  = DIFF_W'(ax_i) - DIFF_W'(bx_i);
    dy1_d  = DIFF_W'(ay_i) - DIFF_W'(by_i);
    prod_x = dx1_q * dx1_q;
    prod_y = dy1_q * dy1_q;
    sx2_d  = prod_x[SQ_W-1:0];
    sy2_d  = prod_y[SQ_W-1:0];
    d3_d   = {1'b0, sx2_q} + {1'b0, sy2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= tag_i;
    dx1_q <= dx1_d;
    dy1_q <= dy1_d;
    t2_q  <= t1_q;
    sx2_q <= sx2_d;
    sy2_q <= sy2_d;
    t3_q  <= t2_q;
    d3_q  <= d3_d;
  end

  assign valid_o = v3_q;
  assign tag_o   = t3_q;
  assign dist_o  = d3_q;
  assign busy_o  = v1_q | v2_q | v3_q;

endmodule

>>> hw/rtl/greedy_geographic_next_hop_unit.sv
// Greedy geographic next hop unit. A neighbour table of id and x,y position lives in one
// synchronous ram; each request scans the filled entries one per cycle, a hello updates or
// appends its neighbour or flags a drop when the table is full, and a query returns the
// closest neighbour strictly nearer the destination than this node, earliest entry on ties.
// Each request runs the ram read scan followed by the three stage distance pipeline drain.
// No clearing pass is needed after reset. The own position is to be written by the user
// through the configuration port only while idle; the block itself does not enforce this.
// depends on ggnh_pkg, ggnh_ram and ggnh_dist_unit
`timescale 1ns / 1ps

module greedy_geographic_next_hop_unit
  import ggnh_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  state_e                    state_q, state_d;
  req_t                      req_q;
  logic [CNT_W-1:0]          scan_q, scan_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [COORD_W-1:0] own_x_q, own_y_q;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_addr_q;
  logic                      matched_q, matched_d;
  logic [IDX_W-1:0]          match_idx_q, match_idx_d;
  logic [DIST_W-1:0]         best_q, best_d;
  logic [ID_W-1:0]           hop_q, hop_d;
  logic                      found_q, found_d;
  rsp_t                      res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  rsp_t                      out_rsp_q, out_rsp_d;

  logic                      accept;
  logic                      rd_en;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  entry_t                    wentry;
  entry_t                    rentry;
  logic [ENTRY_W-1:0]        rdata;

  logic                      du_valid;
  dist_tag_t                 du_tag;
  logic signed [COORD_W-1:0] du_ax, du_ay, du_bx, du_by;
  logic                      dv_valid;
  dist_tag_t                 dv_tag;
  logic [DIST_W-1:0]         dv_dist;
  logic                      dv_busy;

  assign rentry = entry_t'(rdata);

  ggnh_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .re_i   (rd_en),
    .raddr_i(scan_q[IDX_W-1:0]),
    .rdata_o(rdata)
  );

  ggnh_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(du_valid),
    .tag_i  (du_tag),
    .ax_i   (du_ax),
    .ay_i   (du_ay),
    .bx_i   (du_bx),
    .by_i   (du_by),
    .valid_o(dv_valid),
    .tag_o  (dv_tag),
    .dist_o (dv_dist),
    .busy_o (dv_busy)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_q >= count_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !dv_busy) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    accept      = in_valid_i && in_ready_o;
    rd_en       = (state_q == ST_SCAN) && (scan_q < count_q);
    cfg_ready_o = 1'b1;

    // own position enters the distance pipeline first, table entries follow
    du_valid    = accept | rd_vld_q;
    du_tag.own  = accept;
    du_tag.id   = rentry.id;
    du_ax       = accept ? own_x_q : rentry.x;
    du_ay       = accept ? own_y_q : rentry.y;
    du_bx       = accept ? in_req_i.pos_x : req_q.pos_x;
    du_by       = accept ? in_req_i.pos_y : req_q.pos_y;

    scan_d      = scan_q;
    count_d     = count_q;
    matched_d   = matched_q;
    match_idx_d = match_idx_q;
    best_d      = best_q;
    hop_d       = hop_q;
    found_d     = found_q;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = count_q[IDX_W-1:0];
    wentry.id   = req_q.neighbor_id;
    wentry.x    = req_q.pos_x;
    wentry.y    = req_q.pos_y;

    if (accept) begin
      scan_d    = '0;
      matched_d = 1'b0;
    end
    if (rd_en) begin
      scan_d = scan_q + 1'b1;
    end
    if (rd_vld_q && !matched_q && (rentry.id == req_q.neighbor_id)) begin
      matched_d   = 1'b1;
      match_idx_d = rd_addr_q;
    end

    if (dv_valid) begin
      if (dv_tag.own) begin
        best_d  = dv_dist;
        hop_d   = '0;
        found_d = 1'b0;
      end else if (dv_dist < best_q) begin
        best_d  = dv_dist;
        hop_d   = dv_tag.id;
        found_d = 1'b1;
      end
    end

    if (state_q == ST_FINISH) begin
      res_d = '0;
      if (req_q.mode == MODE_QUERY) begin
        res_d.next_hop  = hop_q;
        res_d.hop_found = found_q;
      end else if (matched_q) begin
        we    = 1'b1;
        waddr = match_idx_q;
      end else if (count_q < DEPTH_CNT) begin
        we      = 1'b1;
        count_d = count_q + 1'b1;
      end else begin
        res_d.table_full_drop = 1'b1;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    if ((state_q == ST_RESP) && (!out_valid_q || out_ready_i)) begin
      out_valid_d = 1'b1;
      out_rsp_d   = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      matched_q   <= 1'b0;
      out_valid_q <= 1'b0;
      own_x_q     <= '0;
      own_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_en;
      matched_q   <= matched_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_OWN_X: own_x_q <= cfg_data_i;
          CFG_OWN_Y: own_y_q <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
    rd_addr_q   <= scan_q[IDX_W-1:0];
    match_idx_q <= match_idx_d;
    best_q      <= best_d;
    hop_q       <= hop_d;
    found_q     <= found_d;
    res_q       <= res_d;
    out_rsp_q   <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsp_q.table_full_drop |-> count_q == DEPTH_CNT)
    else $error("drop reported with room in the table");

  a_drop_excl_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_rsp_q.hop_found && out_rsp_q.table_full_drop))
    else $error("drop and hop found together");

  a_no_hop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_rsp_q.hop_found |-> out_rsp_q.next_hop == '0)
    else $error("next hop set without a hop found");

  a_write_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !rd_vld_q && !dv_busy && (state_q == ST_FINISH))
    else $error("table write while the scan is in flight");

endmodule
